// File: rtl/lbc_pkg.sv
`default_nettype none

package lbc_pkg;

  // default number of cache slots and the bounds on the slot index
  localparam int SLOTS_DEFAULT = 32;
  localparam int IDX_MAX_W     = 8;   // enough for up to 256 slots
  localparam int RANGE_W       = 9;   // holds the slot count itself

  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int CNT_W   = 8;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 5;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_GET     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PIN     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNPIN   = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDER  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_SAT    = 2'd3;

  // slot update applied by the addressed cell
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_HIT,
    UPD_PIN,
    UPD_UNPIN,
    UPD_RELEASE,
    UPD_FILL
  } upd_op_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    upd_op_e               op;
    logic [IDX_MAX_W-1:0]  idx;
    logic [DEV_W-1:0]      dev;
    logic [BLK_W-1:0]      blk;
    logic [TIME_W-1:0]     now;
  } bcast_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                  vld;
    logic                  found;
    logic [IDX_MAX_W-1:0]  found_idx;
    logic [CNT_W-1:0]      found_cnt;
    logic                  found_valid;
    logic                  vok;
    logic [IDX_MAX_W-1:0]  vidx;
    logic [TIME_W-1:0]     vtime;
  } carry_t;

endpackage

`default_nettype wire

// File: rtl/lbc_cell.sv
`default_nettype none

module lbc_cell
  import lbc_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bcast_t           bc_i,
  input  wire carry_t           carry_i,
  output      carry_t           carry_o,
  output      logic [CNT_W-1:0] cnt_o
);

  logic [DEV_W-1:0]  tag_dev_q, tag_dev_d;
  logic [BLK_W-1:0]  tag_blk_q, tag_blk_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic              valid_q, valid_d;
  carry_t            carry_q, carry_d;
  logic              sel;
  logic              match;

  assign sel   = (bc_i.idx == IDX_MAX_W'(CELL_IDX)) && (bc_i.op != UPD_NONE);
  assign match = (tag_dev_q == bc_i.dev) && (tag_blk_q == bc_i.blk);

  // fold this slot into the passing token: first tag match, oldest free slot
  always_comb begin
    carry_d = carry_i;
    if (match && !carry_i.found) begin
      carry_d.found       = 1'b1;
      carry_d.found_idx   = IDX_MAX_W'(CELL_IDX);
      carry_d.found_cnt   = cnt_q;
      carry_d.found_valid = valid_q;
    end
    if (cnt_q == '0 && (!carry_i.vok || time_q < carry_i.vtime)) begin
      carry_d.vok   = 1'b1;
      carry_d.vidx  = IDX_MAX_W'(CELL_IDX);
      carry_d.vtime = time_q;
    end
  end

  always_comb begin
    tag_dev_d = tag_dev_q;
    tag_blk_d = tag_blk_q;
    cnt_d     = cnt_q;
    time_d    = time_q;
    valid_d   = valid_q;
    if (sel) begin
      unique case (bc_i.op)
        UPD_HIT: begin
          cnt_d   = cnt_q + 1'b1;
          valid_d = 1'b1;
        end
        UPD_PIN: begin
          cnt_d = cnt_q + 1'b1;
        end
        UPD_UNPIN: begin
          cnt_d = cnt_q - 1'b1;
        end
        UPD_RELEASE: begin
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            time_d = bc_i.now;
          end
        end
        UPD_FILL: begin
          tag_dev_d = bc_i.dev;
          tag_blk_d = bc_i.blk;
          cnt_d     = CNT_W'(1);
          valid_d   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_dev_q <= '0;
      tag_blk_q <= '0;
      cnt_q     <= '0;
      time_q    <= '0;
      valid_q   <= 1'b0;
      carry_q   <= '0;
    end else begin
      tag_dev_q <= tag_dev_d;
      tag_blk_q <= tag_blk_d;
      cnt_q     <= cnt_d;
      time_q    <= time_d;
      valid_q   <= valid_d;
      carry_q   <= carry_d;
    end
  end

  assign carry_o = carry_q;
  assign cnt_o   = cnt_q;

endmodule

`default_nettype wire

// File: rtl/lru_block_buffer_cache.sv
// channel   dir  word fields (lowest bit up)
// s_axis    in   tuser: req_type[1:0]
//                tdata: device[7:0] block_number[39:8] slot_in[44:40] now[76:45]
// m_axis    out  tdata: slot_out[4:0] hit[5] fill_needed[6] status[8:7]
//
// get: the result waits for the search token, which walks the row of slot cells
//   one cell per cycle
// release, pin, unpin: one count read and one update
// one request in flight at a time; a new word is taken while the last result
//   still sits in the output register
// reset clears every slot (tags zero, counts zero, all invalid) at once
`default_nettype none

module lru_block_buffer_cache
  import lbc_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,   // device, block_number, slot_in, now
  input  wire logic [1:0]  s_axis_tuser,   // req_type
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata    // slot_out, hit, fill_needed, status
);

  localparam int IW = $clog2(SLOTS);

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              start_q;
  logic [REQ_W-1:0]  req_q;
  logic [DEV_W-1:0]  dev_q;
  logic [BLK_W-1:0]  blk_q;
  logic [SLOT_W-1:0] slot_q;
  logic [TIME_W-1:0] now_q;

  // pending result, moved to the output register in S_DONE
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic              res_hit_q, res_hit_d;
  logic              res_fill_q, res_fill_d;
  logic [STAT_W-1:0] res_stat_q, res_stat_d;

  logic              out_vld_q;
  logic [15:0]       out_data_q;

  logic              in_acc;
  logic              out_free;
  logic              in_range;
  logic [IW-1:0]     sel_idx;
  logic [CNT_W-1:0]  sel_cnt;

  bcast_t            bc;
  carry_t            tok_head;
  carry_t            carry_w [SLOTS+1];
  logic [CNT_W-1:0]  cnt_w [SLOTS];
  logic [SLOTS-1:0]  tok_vld;
  carry_t            tok_last;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  // ---------------------------------------------------------------------------
  // row of slot cells; the search token enters at cell 0
  // ---------------------------------------------------------------------------
  always_comb begin
    tok_head     = '0;
    tok_head.vld = start_q;
  end

  assign carry_w[0] = tok_head;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lbc_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bc_i    (bc),
      .carry_i (carry_w[i]),
      .carry_o (carry_w[i+1]),
      .cnt_o   (cnt_w[i])
    );
    assign tok_vld[i] = carry_w[i+1].vld;
  end

  assign tok_last = carry_w[SLOTS];

  // count of the slot named by release, pin and unpin
  assign in_range = {{(RANGE_W-SLOT_W){1'b0}}, slot_q} < RANGE_W'(SLOTS);
  assign sel_idx  = IW'(slot_q);
  assign sel_cnt  = cnt_w[sel_idx];

  // ---------------------------------------------------------------------------
  // request decision and slot update
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    res_slot_d = res_slot_q;
    res_hit_d  = res_hit_q;
    res_fill_d = res_fill_q;
    res_stat_d = res_stat_q;
    bc.op      = UPD_NONE;
    bc.idx     = IDX_MAX_W'(slot_q);
    bc.dev     = dev_q;
    bc.blk     = blk_q;
    bc.now     = now_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == REQ_GET) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_SCAN: begin
        if (tok_last.vld) begin
          state_d = S_DONE;
          if (tok_last.found) begin
            res_slot_d = SLOT_W'(tok_last.found_idx);
            res_hit_d  = 1'b1;
            bc.idx     = tok_last.found_idx;
            if (tok_last.found_cnt == COUNT_MAX) begin
              res_fill_d = 1'b0;
              res_stat_d = STAT_SAT;
            end else begin
              bc.op      = UPD_HIT;
              res_fill_d = !tok_last.found_valid;
              res_stat_d = STAT_OK;
            end
          end else if (tok_last.vok) begin
            // miss: retag the oldest free slot, always needs a disk read
            bc.op      = UPD_FILL;
            bc.idx     = tok_last.vidx;
            res_slot_d = SLOT_W'(tok_last.vidx);
            res_hit_d  = 1'b0;
            res_fill_d = 1'b1;
            res_stat_d = STAT_OK;
          end else begin
            res_slot_d = '0;
            res_hit_d  = 1'b0;
            res_fill_d = 1'b0;
            res_stat_d = STAT_NOFREE;
          end
        end
      end

      S_EXEC: begin
        state_d    = S_DONE;
        res_slot_d = slot_q;
        res_hit_d  = 1'b0;
        res_fill_d = 1'b0;
        res_stat_d = STAT_OK;
        if (!in_range) begin
          res_stat_d = STAT_OK;
        end else if (req_q == REQ_PIN) begin
          if (sel_cnt == COUNT_MAX) begin
            res_stat_d = STAT_SAT;
          end else begin
            bc.op = UPD_PIN;
          end
        end else if (sel_cnt == '0) begin
          res_stat_d = STAT_UNDER;
        end else if (req_q == REQ_RELEASE) begin
          bc.op = UPD_RELEASE;
        end else begin
          bc.op = UPD_UNPIN;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      start_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_acc && (s_axis_tuser == REQ_GET);
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= s_axis_tuser;
      dev_q  <= s_axis_tdata[7:0];
      blk_q  <= s_axis_tdata[39:8];
      slot_q <= s_axis_tdata[44:40];
      now_q  <= s_axis_tdata[76:45];
    end
    res_slot_q <= res_slot_d;
    res_hit_q  <= res_hit_d;
    res_fill_q <= res_fill_d;
    res_stat_q <= res_stat_d;
    if (state_q == S_DONE && out_free) begin
      out_data_q <= {7'd0, res_stat_q, res_fill_q, res_hit_q, res_slot_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({start_q, tok_vld}))
    else $error("more than one search token in the cell row");

  a_token_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q || tok_vld != '0) |-> (state_q == S_SCAN))
    else $error("search token outside of a get");

  a_update_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bc.op != UPD_NONE) |=> (state_q == S_DONE))
    else $error("slot update not followed by a result");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> m_axis_tvalid)
    else $error("finished request did not reach the output");

endmodule

`default_nettype wire

// File: dv/testbench.sv
module testbench;
  import lbc_pkg::*;

  localparam int NSLOTS      = SLOTS_DEFAULT;
  localparam int TAG_POOL    = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = NSLOTS + 30;  // covers the longest get latency

  // one result word, slot_out in the lowest bits
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              fill;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } reply_t;

  typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_e;

  // mirror of the slot table, predicts the reply to every accepted request
  class cache_tracker;
    logic [DEV_W-1:0]  tag_dev [NSLOTS];
    logic [BLK_W-1:0]  tag_blk [NSLOTS];
    logic [CNT_W-1:0]  refs    [NSLOTS];
    logic [TIME_W-1:0] stamp   [NSLOTS];
    logic              filled  [NSLOTS];
    reply_t            replies_due [$];
    int                mismatches;

    function new();
      for (int i = 0; i < NSLOTS; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        refs[i]    = '0;
        stamp[i]   = '0;
        filled[i]  = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void take_request(logic [REQ_W-1:0] req, logic [DEV_W-1:0] dev,
                               logic [BLK_W-1:0] blk, logic [SLOT_W-1:0] slot,
                               logic [TIME_W-1:0] now);
      reply_t r;
      int     found;
      int     victim;
      r = '0;
      found = -1;
      victim = -1;
      if (req == REQ_GET) begin
        // tags match whatever the valid mark, lowest index wins
        for (int i = 0; i < NSLOTS; i++)
          if (found < 0 && tag_dev[i] == dev && tag_blk[i] == blk) found = i;
        if (found >= 0) begin
          r.slot = found[SLOT_W-1:0];
          r.hit  = 1'b1;
          if (refs[found] == COUNT_MAX) begin
            r.status = STAT_SAT;
          end else begin
            refs[found]   = refs[found] + 1'b1;
            r.fill        = !filled[found];
            filled[found] = 1'b1;
            r.status      = STAT_OK;
          end
        end else begin
          // free slot with the oldest stamp, ties to the lowest index
          for (int i = 0; i < NSLOTS; i++)
            if (refs[i] == '0 && (victim < 0 || stamp[i] < stamp[victim])) victim = i;
          if (victim < 0) begin
            r.status = STAT_NOFREE;
          end else begin
            tag_dev[victim] = dev;
            tag_blk[victim] = blk;
            refs[victim]    = CNT_W'(1);
            filled[victim]  = 1'b1;
            r.slot   = victim[SLOT_W-1:0];
            r.fill   = 1'b1;
            r.status = STAT_OK;
          end
        end
      end else begin
        r.slot   = slot;
        r.status = STAT_OK;
        if (int'(slot) < NSLOTS) begin
          if (req == REQ_PIN) begin
            if (refs[slot] == COUNT_MAX) r.status = STAT_SAT;
            else refs[slot] = refs[slot] + 1'b1;
          end else if (refs[slot] == '0) begin
            r.status = STAT_UNDER;
          end else begin
            refs[slot] = refs[slot] - 1'b1;
            if (req == REQ_RELEASE && refs[slot] == '0) stamp[slot] = now;
          end
        end
      end
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [15:0] word);
      reply_t got;
      reply_t want;
      got = word[$bits(reply_t)-1:0];
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: result word %h with no request pending", word);
      end else begin
        want = replies_due.pop_front();
        if (got.slot != want.slot || got.hit != want.hit || got.fill != want.fill ||
            got.status != want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: slot %0d/%0d hit %0d/%0d fill %0d/%0d status %0d/%0d (exp/got)",
                     want.slot, got.slot, want.hit, got.hit, want.fill, got.fill,
                     want.status, got.status);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;   // device, block_number, slot_in, now
  logic [1:0]  s_axis_tuser;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // slot_out, hit, fill_needed, status

  cache_tracker tracker = new();

  logic [DEV_W-1:0]  pool_dev [TAG_POOL];
  logic [BLK_W-1:0]  pool_blk [TAG_POOL];
  logic [TIME_W-1:0] tick;
  logic              tx_steady;
  logic              rx_steady;
  int                words_sent;
  int                cycle_count;

  lru_block_buffer_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one request word; valid stays up when the next word follows at once
  task automatic send_word(logic [REQ_W-1:0] req, logic [DEV_W-1:0] dev,
                           logic [BLK_W-1:0] blk, logic [SLOT_W-1:0] slot,
                           logic [TIME_W-1:0] now);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, now, slot, blk, dev};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_request(req, dev, blk, slot, now);
    words_sent++;
    if (words_sent % 40 == 0) tx_steady = ($urandom_range(0, 3) == 0);
  endtask

  // mostly a slot that holds references, so releases and unpins do real work
  function automatic logic [SLOT_W-1:0] held_slot();
    int start;
    start = $urandom_range(0, NSLOTS - 1);
    for (int k = 0; k < NSLOTS; k++)
      if (tracker.refs[(start + k) % NSLOTS] != '0) return SLOT_W'((start + k) % NSLOTS);
    return SLOT_W'(start);
  endfunction

  task automatic random_word(mix_e mix);
    int               roll;
    int               pick;
    int               get_pct;
    int               rel_pct;
    int               pin_pct;
    logic [REQ_W-1:0] req;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic [SLOT_W-1:0] slot;
    case (mix)
      MIX_FILL: begin
        get_pct = 75; rel_pct = 10; pin_pct = 10;
      end
      MIX_DRAIN: begin
        get_pct = 20; rel_pct = 55; pin_pct = 5;
      end
      default: begin
        get_pct = 45; rel_pct = 30; pin_pct = 10;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < get_pct) req = REQ_GET;
    else if (roll < get_pct + rel_pct) req = REQ_RELEASE;
    else if (roll < get_pct + rel_pct + pin_pct) req = REQ_PIN;
    else req = REQ_UNPIN;
    dev  = DEV_W'($urandom);
    blk  = $urandom;
    slot = SLOT_W'($urandom);
    if (req == REQ_GET) begin
      if ($urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, TAG_POOL - 1);
        dev  = pool_dev[pick];
        blk  = pool_blk[pick];
      end
    end else if ($urandom_range(0, 4) != 0) begin
      slot = held_slot();
    end
    // mostly a slowly rising clock, with equal stamps now and then
    if ($urandom_range(0, 3) != 0) tick = tick + $urandom_range(0, 50);
    else tick = $urandom;
    send_word(req, dev, blk, slot, tick);
  endtask

  // drive one slot to the count ceiling, then probe it there
  task automatic saturate_one();
    logic [SLOT_W-1:0] slot;
    slot = held_slot();
    while (tracker.refs[slot] != COUNT_MAX)
      send_word(REQ_PIN, DEV_W'($urandom), $urandom, slot, tick);
    send_word(REQ_PIN, DEV_W'($urandom), $urandom, slot, tick);
    send_word(REQ_GET, tracker.tag_dev[slot], tracker.tag_blk[slot], SLOT_W'($urandom),
              tick);
    send_word(REQ_PIN, DEV_W'($urandom), $urandom, slot, tick);
    repeat (3) send_word(REQ_UNPIN, DEV_W'($urandom), $urandom, slot, tick);
  endtask

  // result side, with its own random backpressure
  initial begin
    int words_taken;
    int stall;
    words_taken = 0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_reply(m_axis_tdata);
      words_taken++;
      if (words_taken % 40 == 0) rx_steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    mix_e mix;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    tick          = '0;
    words_sent    = 0;
    cycle_count   = 0;
    pool_dev[0] = '0;
    pool_blk[0] = '0;
    pool_dev[1] = '1;
    pool_blk[1] = '1;
    for (int i = 2; i < TAG_POOL; i++) begin
      pool_dev[i] = DEV_W'($urandom);
      pool_blk[i] = $urandom;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset every slot carries tag (0, 0), so this hits slot 0 with a fill
    send_word(REQ_GET, 8'h00, 32'h0000_0000, 5'd0, 32'd0);
    send_word(REQ_GET, 8'h00, 32'h0000_0000, 5'd31, 32'd0);
    send_word(REQ_GET, 8'hff, 32'hffff_ffff, 5'd0, 32'hffff_ffff);
    send_word(REQ_PIN, 8'hff, 32'hffff_ffff, 5'd31, 32'd0);
    send_word(REQ_UNPIN, 8'h00, 32'h0000_0000, 5'd31, 32'hffff_ffff);
    // count already zero
    send_word(REQ_UNPIN, 8'h00, 32'h0000_0000, 5'd31, 32'd0);
    send_word(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd7, 32'd0);
    send_word(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd1, 32'hffff_ffff);
    send_word(REQ_UNPIN, 8'h00, 32'h0000_0000, 5'd0, 32'd5);
    send_word(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'd0);
    send_word(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'd0);
    // miss with equal oldest stamps on all free slots but slot 1, lowest such slot taken
    send_word(REQ_GET, 8'h01, 32'h8000_0000, 5'd0, 32'd0);
    send_word(REQ_GET, 8'h00, 32'h0000_0000, 5'd0, 32'd0);
    send_word(REQ_PIN, 8'h00, 32'h0000_0000, 5'd2, 32'd0);
    send_word(REQ_GET, 8'haa, 32'h5555_5555, 5'd21, 32'd0);
    send_word(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd3, 32'h0000_0010);
    send_word(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd2, 32'h0000_0020);
    send_word(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd2, 32'h0000_0030);
    send_word(REQ_GET, 8'h55, 32'haaaa_aaaa, 5'd10, 32'd0);
    send_word(REQ_GET, 8'hff, 32'hffff_ffff, 5'd0, 32'd0);

    for (int chunk = 0; chunk < 10; chunk++) begin
      if (chunk == 1) mix = MIX_FILL;
      else if (chunk == 2) mix = MIX_DRAIN;
      else mix = mix_e'($urandom_range(0, 2));
      if (chunk == 4) saturate_one();
      repeat (75) random_word(mix);
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
